// ===== rtl/core/lts_pkg.sv =====
// Shared types and constants for the lap time statistics block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lts_pkg;

    localparam int MAX_LAPS    = 64;
    localparam int LAP_W       = 32;
    localparam int CNT_W       = $clog2(MAX_LAPS + 1);
    localparam int TOTAL_W     = 34;
    localparam int COUNT_OUT_W = 7;
    localparam int BEST_K      = 3;

    // Result tdata layout, lowest bit first.
    localparam int FAST_LSB   = 0;
    localparam int MEDIAN_LSB = FAST_LSB + LAP_W;
    localparam int TOTAL_LSB  = MEDIAN_LSB + LAP_W;
    localparam int COUNT_LSB  = TOTAL_LSB + TOTAL_W;
    localparam int RES_BITS   = COUNT_LSB + COUNT_OUT_W;
    localparam int M_DATA_W   = ((RES_BITS + 7) / 8) * 8;

    typedef logic [LAP_W-1:0] lap_t;

    // What one cell shows to its neighbours.
    typedef struct packed {
        lap_t val;
        logic valid;
        logic keep;
    } cell_link_t;

    // Broadcast control for the whole chain.
    typedef struct packed {
        logic insert;
        logic shift;
        lap_t lap;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_COLLECT = 3'b001,
        ST_DRAIN   = 3'b010,
        ST_FINISH  = 3'b100
    } lts_state_t;

endpackage

// ===== rtl/core/lap_time_statistics.sv =====
// Top level of the lap time statistics block: insertion chain and readout.
// Depends on lts_pkg and instantiates lts_cell once per stored lap.
`timescale 1ns / 1ps

// Usage
// Lap times arrive on the s_ channel, one request per lap, with s_tlast set
// on the final lap of a list. Each lap is placed into sorted order by a row
// of cells in the cycle it is accepted, so laps are taken at one per cycle
// while collecting. After the last lap the chain is shifted towards its head,
// one lap per cycle, and the fastest lap, the median and the sum of the
// three smallest laps are gathered as the laps pass the head. The readout
// passes each kept lap (1 to 64) by the head; the finish state then loads
// the result once the output register is free. The readout also empties
// the chain, so no separate clearing pass is needed. New laps are refused
// (s_tready low) from the last lap until the result is loaded.
// Laps arriving on a full store are dropped and flagged in m_tuser.
// While the receiver stalls, the result request is held stable; the next
// list may still be collected, but its result waits for the register.
// Reset (aresetn low, synchronous) empties the chain and drops any result.
module lap_time_statistics (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lts_pkg::LAP_W-1:0]    s_tdata,  // [31:0] lap_time
    input  logic                         s_tlast,  // last_lap
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] fastest_lap, [63:32] median_lap, [97:64] best_three_total,
    // [104:98] lap_count, [111:105] zero
    output logic [lts_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tuser   // overflow
);
    import lts_pkg::*;

    lts_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    lap_t             fast_reg, fast_next;
    logic [LAP_W:0]   med_reg, med_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;

    logic       s_accept;
    logic       full;
    cell_ctrl_t ctrl;
    cell_link_t links [MAX_LAPS];
    cell_link_t left_links [MAX_LAPS];
    cell_link_t right_links [MAX_LAPS];
    lap_t       head;
    logic [CNT_W-1:0] mid;
    logic       even;
    logic       out_free;
    lap_t       median;

    assign s_tready = (state_reg == ST_COLLECT);
    assign s_accept = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(MAX_LAPS));
    assign out_free = !m_valid_reg || m_tready;

    assign ctrl = '{insert: s_accept && !full,
                    shift:  (state_reg == ST_DRAIN),
                    lap:    s_tdata};

    // The row of cells. The left boundary behaves as a valid slot that keeps,
    // so the head cell takes the new lap; empty slots shift in from the right.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_LAPS; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign left_links[gi] = '{val: '1, valid: 1'b1, keep: 1'b1};
            end else begin : g_mid
                assign left_links[gi] = links[gi-1];
            end
            if (gi == MAX_LAPS - 1) begin : g_last
                assign right_links[gi] = '{val: '1, valid: 1'b0, keep: 1'b0};
            end else begin : g_inner
                assign right_links[gi] = links[gi+1];
            end
            lts_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .left_in  (left_links[gi]),
                .right_in (right_links[gi]),
                .link_out (links[gi])
            );
        end
    endgenerate

    assign head   = links[0].val;
    assign mid    = n_reg >> 1;
    assign even   = !n_reg[0];
    assign median = even ? med_reg[LAP_W:1] : med_reg[LAP_W-1:0];

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        n_next       = n_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        fast_next    = fast_reg;
        med_next     = med_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_COLLECT: begin
                if (s_accept) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        n_next       = full ? count_reg : count_reg + 1'b1;
                        ovf_next     = dropped_reg || full;
                        count_next   = '0;
                        dropped_next = 1'b0;
                        idx_next     = '0;
                        fast_next    = '0;
                        med_next     = '0;
                        total_next   = '0;
                        // The last lap always leaves at least one lap kept.
                        state_next   = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (n_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    if (idx_reg == '0) begin
                        fast_next = head;
                    end
                    if (idx_reg < CNT_W'(BEST_K)) begin
                        total_next = total_reg + TOTAL_W'(head);
                    end
                    if (idx_reg == mid || (even && idx_reg == mid - 1'b1)) begin
                        med_next = med_reg + (LAP_W+1)'(head);
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == n_reg - 1'b1) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[FAST_LSB +: LAP_W]          = fast_reg;
                    m_data_next[MEDIAN_LSB +: LAP_W]        = median;
                    m_data_next[TOTAL_LSB +: TOTAL_W]       = total_reg;
                    m_data_next[COUNT_LSB +: COUNT_OUT_W]   = COUNT_OUT_W'(n_reg);
                    m_user_next  = ovf_reg;
                    state_next   = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg      <= n_next;
        ovf_reg    <= ovf_next;
        idx_reg    <= idx_next;
        fast_reg   <= fast_next;
        med_reg    <= med_next;
        total_reg  <= total_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== rtl/core/lts_cell.sv =====
// One slot of the sorted insertion chain.
// Depends on lts_pkg for the link and control types.
`timescale 1ns / 1ps

module lts_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  lts_pkg::cell_ctrl_t ctrl,
    input  lts_pkg::cell_link_t left_in,
    input  lts_pkg::cell_link_t right_in,
    output lts_pkg::cell_link_t link_out
);
    import lts_pkg::*;

    lap_t val_reg, val_next;
    logic valid_reg, valid_next;
    logic keep;

    // A cell keeps its value when it holds a lap no larger than the new one,
    // so equal laps land behind those already stored.
    assign keep = valid_reg && (val_reg <= ctrl.lap);

    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            val_next   = right_in.val;
            valid_next = right_in.valid;
        end else if (ctrl.insert) begin
            valid_next = valid_reg | left_in.valid;
            if (!keep) begin
                val_next = left_in.keep ? ctrl.lap : left_in.val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        val_reg <= val_next;
    end

    assign link_out = '{val: val_reg, valid: valid_reg, keep: keep};

endmodule

// ===== rtl/core/lts_checker.sv =====
// Port-level checks for the lap time statistics block, bound to its top level.
// Depends on lts_pkg for the result layout and the store capacity.
`timescale 1ns / 1ps

module lts_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lts_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import lts_pkg::*;

    // A stalled result request holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // After the last lap of a list the block reads out before taking more laps.
    a_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("lap accepted during readout");

    // Every result covers at least one kept lap.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[COUNT_LSB +: COUNT_OUT_W] != '0)
        else $error("result with no laps");

    // Laps are only dropped from a full store.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[COUNT_LSB +: COUNT_OUT_W] == COUNT_OUT_W'(MAX_LAPS))
        else $error("overflow flagged below capacity");

endmodule

bind lap_time_statistics lts_checker u_lts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/lap_stats_checker.sv =====
`timescale 1ns / 1ps
// Checker for the lap time statistics block: keeps its own sorted list of laps,
// predicts each list result and compares it with the result channel. Uses lts_pkg.

module lap_stats_checker
    import lts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  lap_t                s_tdata,
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tuser,
    output int                  mismatch_count,
    output int                  results_pending
);

    typedef struct packed {
        lap_t                   fastest;
        lap_t                   median;
        logic [TOTAL_W-1:0]     best_three;
        logic [COUNT_OUT_W-1:0] laps_kept;
        logic                   overflow;
    } list_summary_t;

    lap_t          ordered_laps [MAX_LAPS];
    int            kept_laps    = 0;
    logic          laps_dropped = 1'b0;
    list_summary_t summaries_due [$];
    int            mismatches   = 0;
    int            mismatch_reg = 0;
    int            pending_reg  = 0;

    assign mismatch_count  = mismatch_reg;
    assign results_pending = pending_reg;

    // Equal laps go behind those already stored, as in the insertion chain.
    function automatic void place_lap(lap_t lap);
        int slot;
        if (kept_laps >= MAX_LAPS) begin
            laps_dropped = 1'b1;
            return;
        end
        slot = kept_laps;
        while (slot > 0 && ordered_laps[slot-1] > lap) begin
            ordered_laps[slot] = ordered_laps[slot-1];
            slot--;
        end
        ordered_laps[slot] = lap;
        kept_laps++;
    endfunction

    function automatic list_summary_t summarise_list();
        list_summary_t   summary;
        logic [LAP_W:0]  middle_pair;
        int              mid;
        summary = '0;
        if (kept_laps > 0) begin
            mid = kept_laps / 2;
            summary.fastest = ordered_laps[0];
            if (kept_laps % 2 == 0) begin
                middle_pair = {1'b0, ordered_laps[mid-1]} + {1'b0, ordered_laps[mid]};
                summary.median = middle_pair[LAP_W:1];
            end else begin
                summary.median = ordered_laps[mid];
            end
            for (int i = 0; i < BEST_K && i < kept_laps; i++) begin
                summary.best_three += TOTAL_W'(ordered_laps[i]);
            end
        end
        summary.laps_kept = COUNT_OUT_W'(kept_laps);
        summary.overflow  = laps_dropped;
        return summary;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] seen);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, seen);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        list_summary_t due;
        if (!aresetn) begin
            kept_laps    = 0;
            laps_dropped = 1'b0;
            summaries_due.delete();
        end else begin
            // A result always belongs to an earlier list than a last lap taken
            // at the same edge, so the result is checked first.
            if (m_tvalid && m_tready) begin
                if (summaries_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_tdata[63:0]);
                end else begin
                    due = summaries_due.pop_front();
                    if (m_tdata[FAST_LSB +: LAP_W] !== due.fastest)
                        report_mismatch("fastest_lap", due.fastest, m_tdata[FAST_LSB +: LAP_W]);
                    if (m_tdata[MEDIAN_LSB +: LAP_W] !== due.median)
                        report_mismatch("median_lap", due.median, m_tdata[MEDIAN_LSB +: LAP_W]);
                    if (m_tdata[TOTAL_LSB +: TOTAL_W] !== due.best_three)
                        report_mismatch("best_three_total", due.best_three,
                                        m_tdata[TOTAL_LSB +: TOTAL_W]);
                    if (m_tdata[COUNT_LSB +: COUNT_OUT_W] !== due.laps_kept)
                        report_mismatch("lap_count", due.laps_kept,
                                        m_tdata[COUNT_LSB +: COUNT_OUT_W]);
                    if (m_tuser !== due.overflow)
                        report_mismatch("overflow", due.overflow, m_tuser);
                end
            end
            if (s_tvalid && s_tready) begin
                place_lap(s_tdata);
                if (s_tlast) begin
                    summaries_due.insert(summaries_due.size(), summarise_list());
                    kept_laps    = 0;
                    laps_dropped = 1'b0;
                end
            end
        end
        mismatch_reg <= mismatches;
        pending_reg  <= summaries_due.size();
    end

endmodule

// ===== tb/sv/tb_lap_time_statistics.sv =====
`timescale 1ns / 1ps
// Top of the lap time statistics testbench: clock, reset, lap stimulus and verdict.
// Depends on lts_pkg, the block itself and the lap_stats_checker module.

module tb_lap_time_statistics;

    import lts_pkg::*;

    // Roughly how many laps the run sends in total before it drains.
    localparam int   LAP_TARGET   = 1900;
    // Far beyond the slowest correct run.
    localparam int   CYCLE_LIMIT  = 400000;
    // Wait at the end of the run, sized from MAX_LAPS with a margin on top.
    localparam int   DRAIN_CYCLES = MAX_LAPS + 32;
    localparam lap_t LAP_MAX      = '1;
    localparam int   N_DIRECTED   = 24;

    // Directed lists, one lap per entry with the last-lap flag on top. They
    // cover a lone zero lap, a lone maximum lap, two maximum laps (the middle
    // pair must not wrap), three maximum laps (the widest possible total),
    // repeated equal laps, an even count whose mean must round down, a rising
    // list and a list with alternating bit patterns.
    localparam logic [LAP_W:0] DIRECTED_LAPS [N_DIRECTED] = '{
        {1'b1, 32'h0000_0000},
        {1'b1, 32'hFFFF_FFFF},
        {1'b0, 32'hFFFF_FFFF}, {1'b1, 32'hFFFF_FFFF},
        {1'b0, 32'hFFFF_FFFF}, {1'b0, 32'hFFFF_FFFF}, {1'b1, 32'hFFFF_FFFF},
        {1'b0, 32'd5}, {1'b0, 32'd3}, {1'b0, 32'd5}, {1'b0, 32'd3}, {1'b1, 32'd1},
        {1'b0, 32'd10}, {1'b1, 32'd7},
        {1'b0, 32'd1}, {1'b0, 32'd2}, {1'b0, 32'd4}, {1'b0, 32'd8}, {1'b0, 32'd16},
        {1'b1, 32'h8000_0000},
        {1'b0, 32'h5555_5555}, {1'b0, 32'hAAAA_AAAA}, {1'b0, 32'h0000_0000},
        {1'b1, 32'hFFFF_FFFF}
    };

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    lap_t                s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tready = 1'b0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [M_DATA_W-1:0] m_tdata;
    wire                 m_tuser;

    int          mismatch_count;
    int          results_pending;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          laps_sent      = 0;
    int unsigned cycle_count    = 0;

    always #5 aclk = ~aclk;

    lap_time_statistics u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lap_stats_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Phase 0 has no idling, phase 1 an idle sender, phase 2 a stalling
    // receiver and phase 3 a little of both. The sender's rate is only read by
    // this process; the receiver's is handed over at the clock edge.
    task automatic set_phase(input int phase);
        case (phase)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 0;
            end
            1: begin
                send_idle_pct  = 56;
                recv_stall_pct <= 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct <= 56;
            end
            default: begin
                send_idle_pct  = 16;
                recv_stall_pct <= 16;
            end
        endcase
    endtask

    // Offers one lap request and holds it until the block takes it. While the
    // sender idles, tdata carries junk that the block must ignore. A request
    // that follows straight on keeps tvalid high without lowering it.
    task automatic send_lap(input lap_t lap, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lap;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        laps_sent++;
    endtask

    // Mostly full-range laps, with a share of tiny values so that equal laps
    // are common and a share just below the maximum to stress the adders.
    function automatic lap_t random_lap();
        case ($urandom_range(9))
            0, 1:    return lap_t'($urandom_range(15));
            2:       return LAP_MAX - lap_t'($urandom_range(15));
            default: return lap_t'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        int list_idx;
        int list_len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_phase(0);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_lap(DIRECTED_LAPS[i][LAP_W-1:0], DIRECTED_LAPS[i][LAP_W]);
        end

        // Random lists, mostly short. Every sixteenth list runs from two laps below
        // the capacity of the store to eight laps past it, so laps often get dropped
        // and often the last lap itself falls on a full store.
        list_idx = 0;
        while (laps_sent < LAP_TARGET) begin
            set_phase(laps_sent * 4 / LAP_TARGET);
            if (list_idx % 16 == 5)
                list_len = $urandom_range(MAX_LAPS - 2, MAX_LAPS + 8);
            else
                list_len = $urandom_range(1, 12);
            for (int i = 0; i < list_len; i++) begin
                send_lap(random_lap(), i == list_len - 1);
            end
            list_idx++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // The checker's pending count is registered, hence the wait before the first look at it.
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
